// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros: concurrent assertion helpers
// both macros expand to nothing when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// File: rtl/pgms_pkg.sv
// ----------------------------------------------------------------------------
// pgms_pkg: shared types and codes
// register codes, controller states and the command/status bundles
// ----------------------------------------------------------------------------
package pgms_pkg;

   // statistic codes
   localparam logic [2:0] STAT_MAX  = 3'd0;
   localparam logic [2:0] STAT_MIN  = 3'd1;
   localparam logic [2:0] STAT_MEAN = 3'd2;
   localparam logic [2:0] STAT_STD  = 3'd3;
   localparam logic [2:0] STAT_SKEW = 3'd4;
   localparam logic [2:0] STAT_KURT = 3'd5;

   // subset codes
   localparam logic [1:0] SUBSET_FIRST = 2'd1;
   localparam logic [1:0] SUBSET_FINAL = 2'd2;

   // property codes
   localparam logic [2:0] PROP_ELEV  = 3'd1;
   localparam logic [2:0] PROP_WIDTH = 3'd2;
   localparam logic [2:0] PROP_RISE  = 3'd3;
   localparam logic [2:0] PROP_BACK  = 3'd4;

   // register indexes
   localparam logic [1:0] CSR_STAT   = 2'd0;
   localparam logic [1:0] CSR_SUBSET = 2'd1;
   localparam logic [1:0] CSR_PROP   = 2'd2;
   localparam logic [1:0] CSR_NODATA = 2'd3;

   localparam logic [31:0] NO_DATA_RESET = 32'hD8F1_0000;
   localparam logic [31:0] POS_LIMIT     = 32'h7FFF_FFFF;
   localparam logic [31:0] NEG_LIMIT     = 32'h8000_0000;

   typedef enum logic [4:0] {
      ST_IDLE, ST_CHECK, ST_P1_RD, ST_P1_ACC, ST_MEAN_GO, ST_MEAN_WAIT,
      ST_P2_RD, ST_P2_GO, ST_P2_WAIT, ST_VAR_GO, ST_VAR_WAIT, ST_SQRT_GO,
      ST_SQRT_WAIT, ST_SIG_CHK, ST_P3_RD, ST_P3_DGO, ST_P3_DWAIT, ST_P3_M1GO,
      ST_P3_M1WAIT, ST_P3_M2GO, ST_P3_M2WAIT, ST_FIN_GO, ST_FIN_WAIT, ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      RES_MAX, RES_MIN, RES_MEAN, RES_STD, RES_MOMENT, RES_NODATA, RES_DEGEN
   } res_kind_type;

   typedef enum logic [1:0] {DIV_MEAN, DIV_VAR, DIV_Z, DIV_FIN} div_sel_type;
   typedef enum logic [1:0] {MUL_SQ, MUL_Z2, MUL_ZK} mul_sel_type;

   typedef struct packed {
      logic         idx_clr;
      logic         idx_inc;
      logic         rd;
      logic         p1_acc;
      logic         acc_clr;
      logic         div_go;
      div_sel_type  div_sel;
      logic         mul_go;
      mul_sel_type  mul_sel;
      logic         sqrt_go;
      logic         emit;
      res_kind_type kind;
   } cmd_type;

   typedef struct packed {
      logic       count_zero;
      logic       stat_bad;
      logic       idx_last;
      logic       div_done;
      logic       mul_done;
      logic       sqrt_done;
      logic       sigma_zero;
      logic       out_free;
      logic [2:0] stat_sel;
   } status_type;

endpackage

// File: rtl/pgms_div.sv
// ----------------------------------------------------------------------------
// pgms_div: restoring divider
// unsigned, one quotient bit per cycle, done pulses when quotient is ready
// ----------------------------------------------------------------------------
module pgms_div #(
   parameter int DVW = 68,
   parameter int DSW = 32
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           go,
   input  logic [DVW-1:0] dividend,
   input  logic [DSW-1:0] divisor,
   output logic           busy,
   output logic           done,
   output logic [DVW-1:0] quotient
);

   localparam int CNTW = $clog2(DVW + 1);

   logic            busy_ff;
   logic            done_ff;
   logic [CNTW-1:0] cnt_ff;
   logic [DVW-1:0]  dvd_ff;
   logic [DSW-1:0]  rem_ff;
   logic [DSW-1:0]  dsr_ff;
   logic [DSW:0]    rem_sh;
   logic [DSW:0]    diff;
   logic            ge;
   logic            last;

   assign rem_sh = {rem_ff, dvd_ff[DVW-1]};
   assign diff   = rem_sh - {1'b0, dsr_ff};
   assign ge     = rem_sh >= {1'b0, dsr_ff};
   assign last   = cnt_ff == CNTW'(DVW - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && last;
         if (go) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNTW'(1);
            if (last) busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         dvd_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[DSW-1:0] : rem_sh[DSW-1:0];
         dvd_ff <= {dvd_ff[DVW-2:0], ge};
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

// File: rtl/pgms_mul.sv
// ----------------------------------------------------------------------------
// pgms_mul: multi-cycle multiplier
// unsigned, one 16-bit digit of the second operand per cycle
// ----------------------------------------------------------------------------
module pgms_mul #(
   parameter int MW = 33
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            go,
   input  logic [MW-1:0]   a_in,
   input  logic [MW-1:0]   b_in,
   output logic            done,
   output logic [2*MW-1:0] product
);

   localparam int NCH  = (MW + 15) / 16;
   localparam int BPW  = NCH * 16;
   localparam int PW   = MW + BPW;
   localparam int CNTW = $clog2(NCH + 1);

   logic            busy_ff;
   logic            done_ff;
   logic [CNTW-1:0] cnt_ff;
   logic [MW-1:0]   a_ff;
   logic [BPW-1:0]  b_ff;
   logic [PW-1:0]   acc_ff;
   logic [MW+15:0]  part;
   logic            last;

   assign part = a_ff * b_ff[BPW-1 -: 16];
   assign last = cnt_ff == CNTW'(NCH - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && last;
         if (go) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNTW'(1);
            if (last) busy_ff <= 1'b0;
         end
      end
   end

   // most significant digit first
   always_ff @(posedge clock) begin
      if (go) begin
         a_ff   <= a_in;
         b_ff   <= BPW'(b_in);
         acc_ff <= '0;
      end else if (busy_ff) begin
         acc_ff <= (acc_ff << 16) + PW'(part);
         b_ff   <= b_ff << 16;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff[2*MW-1:0];

endmodule

// File: rtl/pgms_datapath.sv
// ----------------------------------------------------------------------------
// pgms_datapath: value buffer, accumulators and arithmetic units
// holds the registers, the sample store, divider, multiplier and root unit
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pgms_datapath
   import pgms_pkg::*;
#(
   parameter int MAX_VALUES = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   input  logic               req_fire,
   input  logic               req_has_peak,
   input  logic signed [31:0] req_amplitude,
   input  logic signed [31:0] req_elevation,
   input  logic signed [31:0] req_pulse_width,
   input  logic signed [31:0] req_rise_span,
   input  logic signed [31:0] req_backscatter,
   input  logic [7:0]         req_position_in_wave,
   input  logic               req_final_peak,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_stat_value,
   output logic               rsp_no_data,
   output logic               rsp_degenerate,
   output logic               rsp_overflowed
);

   localparam int AW   = $clog2(MAX_VALUES);
   localparam int CW   = $clog2(MAX_VALUES + 1);
   localparam int SUMW = 32 + AW;
   localparam int DVW  = 64 + AW;
   localparam int MW   = (FRAC_BITS + 14 > 33) ? FRAC_BITS + 14 : 33;
   localparam int ZW   = FRAC_BITS + 7;
   localparam int Z2W  = FRAC_BITS + 14;
   localparam int KW   = FRAC_BITS + 28;
   localparam logic [DVW-1:0] ZCAP = {{(DVW - ZW){1'b0}}, {ZW{1'b1}}};

   // configuration
   logic [2:0]  stat_ff;
   logic [1:0]  subset_ff;
   logic [2:0]  prop_ff;
   logic [31:0] nodata_ff;

   // buffer
   logic [31:0]   store_mem [MAX_VALUES];
   logic [CW-1:0] count_ff;
   logic          dropped_ff;
   logic [AW-1:0] idx_ff;
   logic [31:0]   rd_data_ff;
   logic          keep;
   logic [31:0]   sel_value;
   logic          store_hit;
   logic          room;
   logic          wr_en;

   // statistics
   logic [31:0]     mx_ff;
   logic [31:0]     mn_ff;
   logic [SUMW-1:0] sum_ff;
   logic            sum_neg;
   logic [SUMW-1:0] sum_abs;
   logic [31:0]     mean_ff;
   logic [32:0]     dev;
   logic            dev_neg;
   logic [32:0]     dev_abs;
   logic [DVW-1:0]  sqsum_ff;
   logic [63:0]     var_ff;
   logic [ZW-1:0]   z_ff;
   logic [Z2W-1:0]  z2_ff;
   logic [KW-1:0]   zk;
   logic [DVW-1:0]  zk_ext;
   logic [DVW-1:0]  macc_ff;
   logic            macc_neg;
   logic [DVW-1:0]  macc_abs;
   logic [31:0]     moment_ff;
   logic [31:0]     fin_sat;
   logic [31:0]     sigma;
   logic [31:0]     std_sat;

   // root unit
   logic        sq_busy_ff;
   logic        sq_done_ff;
   logic [63:0] sq_x_ff;
   logic [63:0] sq_res_ff;
   logic [63:0] sq_bit_ff;
   logic [63:0] sq_t;
   logic        sq_ge;

   // shared units
   logic [DVW-1:0] div_dividend;
   logic [31:0]    div_divisor;
   logic           div_busy;
   logic           div_done;
   logic [DVW-1:0] div_q;
   div_sel_type    div_tgt_ff;
   logic [MW-1:0]  mul_a;
   logic [MW-1:0]  mul_b;
   logic           mul_done;
   logic [2*MW-1:0] mul_p;
   mul_sel_type    mul_tgt_ff;

   // output register
   logic        rsp_valid_ff;
   logic [31:0] rsp_value_ff;
   logic        rsp_nd_ff;
   logic        rsp_deg_ff;
   logic        rsp_ovf_ff;
   logic        out_free;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         stat_ff   <= STAT_MAX;
         subset_ff <= '0;
         prop_ff   <= '0;
         nodata_ff <= NO_DATA_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_STAT:   stat_ff   <= csr_wdata[2:0];
            CSR_SUBSET: subset_ff <= csr_wdata[1:0];
            CSR_PROP:   prop_ff   <= csr_wdata[2:0];
            CSR_NODATA: nodata_ff <= csr_wdata;
         endcase
      end
   end

   // ---------------- loading ----------------
   always_comb begin
      priority case (subset_ff)
         SUBSET_FIRST: keep = req_position_in_wave == 8'd1;
         SUBSET_FINAL: keep = req_final_peak;
         default:      keep = 1'b1;
      endcase
      unique case (prop_ff)
         PROP_ELEV:  sel_value = req_elevation;
         PROP_WIDTH: sel_value = req_pulse_width;
         PROP_RISE:  sel_value = req_rise_span;
         PROP_BACK:  sel_value = req_backscatter;
         default:    sel_value = req_amplitude;
      endcase
   end

   assign store_hit = req_fire && req_has_peak && keep;
   assign room      = count_ff < CW'(MAX_VALUES);
   assign wr_en     = store_hit && room;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else if (cmd.emit) begin
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         if (wr_en) count_ff <= count_ff + CW'(1);
         if (store_hit && !room) dropped_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) store_mem[count_ff[AW-1:0]] <= sel_value;
      if (cmd.rd) rd_data_ff <= store_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.idx_clr) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + AW'(1);
      end
   end

   // ---------------- arithmetic ----------------
   assign sum_neg  = sum_ff[SUMW-1];
   assign sum_abs  = sum_neg ? (SUMW'(0) - sum_ff) : sum_ff;
   assign dev      = {rd_data_ff[31], rd_data_ff} - {mean_ff[31], mean_ff};
   assign dev_neg  = dev[32];
   assign dev_abs  = dev_neg ? (33'd0 - dev) : dev;
   assign macc_neg = macc_ff[DVW-1];
   assign macc_abs = macc_neg ? (DVW'(0) - macc_ff) : macc_ff;
   assign zk       = mul_p[FRAC_BITS +: KW];
   assign zk_ext   = DVW'(zk);
   assign sigma    = sq_res_ff[31:0];
   assign std_sat  = sigma[31] ? POS_LIMIT : sigma;

   always_comb begin
      if (!macc_neg) begin
         fin_sat = (div_q > DVW'(POS_LIMIT)) ? POS_LIMIT : div_q[31:0];
      end else begin
         fin_sat = (div_q > DVW'(NEG_LIMIT)) ? NEG_LIMIT : (32'd0 - div_q[31:0]);
      end
   end

   always_comb begin
      unique case (cmd.div_sel)
         DIV_MEAN: begin
            div_dividend = DVW'(sum_abs);
            div_divisor  = 32'(count_ff);
         end
         DIV_VAR: begin
            div_dividend = sqsum_ff;
            div_divisor  = 32'(count_ff);
         end
         DIV_Z: begin
            div_dividend = DVW'(dev_abs) << FRAC_BITS;
            div_divisor  = sigma;
         end
         DIV_FIN: begin
            div_dividend = macc_abs;
            div_divisor  = 32'(count_ff);
         end
      endcase
   end

   always_comb begin
      unique case (cmd.mul_sel)
         MUL_Z2: begin
            mul_a = MW'(z_ff);
            mul_b = MW'(z_ff);
         end
         MUL_ZK: begin
            mul_a = MW'(z2_ff);
            mul_b = (stat_ff == STAT_SKEW) ? MW'(z_ff) : MW'(z2_ff);
         end
         default: begin
            mul_a = MW'(dev_abs);
            mul_b = MW'(dev_abs);
         end
      endcase
   end

   pgms_div #(
      .DVW (DVW),
      .DSW (32)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (cmd.div_go),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q)
   );

   pgms_mul #(
      .MW (MW)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .go      (cmd.mul_go),
      .a_in    (mul_a),
      .b_in    (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         div_tgt_ff <= DIV_MEAN;
         mul_tgt_ff <= MUL_SQ;
      end else begin
         if (cmd.div_go) div_tgt_ff <= cmd.div_sel;
         if (cmd.mul_go) mul_tgt_ff <= cmd.mul_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.p1_acc) begin
         if (idx_ff == '0) begin
            mx_ff  <= rd_data_ff;
            mn_ff  <= rd_data_ff;
            sum_ff <= SUMW'($signed(rd_data_ff));
         end else begin
            if ($signed(rd_data_ff) > $signed(mx_ff)) mx_ff <= rd_data_ff;
            if ($signed(rd_data_ff) < $signed(mn_ff)) mn_ff <= rd_data_ff;
            sum_ff <= sum_ff + SUMW'($signed(rd_data_ff));
         end
      end
      if (cmd.acc_clr) begin
         sqsum_ff <= '0;
         macc_ff  <= '0;
      end
      if (div_done) begin
         unique case (div_tgt_ff)
            DIV_MEAN: mean_ff <= sum_neg ? (32'd0 - div_q[31:0]) : div_q[31:0];
            DIV_VAR:  var_ff  <= div_q[63:0];
            DIV_Z:    z_ff    <= (div_q > ZCAP) ? ZCAP[ZW-1:0] : div_q[ZW-1:0];
            DIV_FIN:  moment_ff <= fin_sat;
         endcase
      end
      if (mul_done) begin
         unique case (mul_tgt_ff)
            MUL_Z2: z2_ff <= mul_p[FRAC_BITS +: Z2W];
            MUL_ZK: begin
               // only the odd moment carries the deviation's sign
               if (dev_neg && stat_ff == STAT_SKEW) macc_ff <= macc_ff - zk_ext;
               else macc_ff <= macc_ff + zk_ext;
            end
            default: sqsum_ff <= sqsum_ff + DVW'(mul_p[63:0]);
         endcase
      end
   end

   // ---------------- integer square root, two bits per cycle ----------------
   assign sq_t  = sq_res_ff + sq_bit_ff;
   assign sq_ge = sq_x_ff >= sq_t;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_busy_ff <= 1'b0;
         sq_done_ff <= 1'b0;
      end else begin
         sq_done_ff <= sq_busy_ff && sq_bit_ff[0];
         if (cmd.sqrt_go) sq_busy_ff <= 1'b1;
         else if (sq_busy_ff && sq_bit_ff[0]) sq_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sqrt_go) begin
         sq_x_ff   <= var_ff;
         sq_res_ff <= '0;
         sq_bit_ff <= 64'h4000_0000_0000_0000;
      end else if (sq_busy_ff) begin
         if (sq_ge) begin
            sq_x_ff   <= sq_x_ff - sq_t;
            sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
         end else begin
            sq_res_ff <= sq_res_ff >> 1;
         end
         sq_bit_ff <= sq_bit_ff >> 2;
      end
   end

   // ---------------- result register ----------------
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ovf_ff <= dropped_ff;
         rsp_nd_ff  <= 1'b0;
         rsp_deg_ff <= 1'b0;
         unique case (cmd.kind)
            RES_MAX:    rsp_value_ff <= mx_ff;
            RES_MIN:    rsp_value_ff <= mn_ff;
            RES_MEAN:   rsp_value_ff <= mean_ff;
            RES_STD:    rsp_value_ff <= std_sat;
            RES_MOMENT: rsp_value_ff <= moment_ff;
            RES_DEGEN: begin
               rsp_value_ff <= nodata_ff;
               rsp_nd_ff    <= 1'b1;
               rsp_deg_ff   <= 1'b1;
            end
            default: begin
               rsp_value_ff <= nodata_ff;
               rsp_nd_ff    <= 1'b1;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_stat_value = rsp_value_ff;
   assign rsp_no_data    = rsp_nd_ff;
   assign rsp_degenerate = rsp_deg_ff;
   assign rsp_overflowed = rsp_ovf_ff;

   // ---------------- status ----------------
   assign status.count_zero = count_ff == '0;
   assign status.stat_bad   = stat_ff > STAT_KURT;
   assign status.idx_last   = (CW'(idx_ff) + CW'(1)) == count_ff;
   assign status.div_done   = div_done;
   assign status.mul_done   = mul_done;
   assign status.sqrt_done  = sq_done_ff;
   assign status.sigma_zero = sq_res_ff == '0;
   assign status.out_free   = out_free;
   assign status.stat_sel   = stat_ff;

   `ASSERT_NEVER(a_count_bound, clock, reset, count_ff > CW'(MAX_VALUES))
   `ASSERT_PROP(a_emit_slot_free, clock, reset, cmd.emit |-> out_free)
   `ASSERT_PROP(a_emit_clears_group, clock, reset, cmd.emit |=> count_ff == '0 && !dropped_ff)
   `ASSERT_PROP(a_div_start_idle, clock, reset, cmd.div_go |-> !div_busy)

endmodule

// File: rtl/pgms_ctrl.sv
// ----------------------------------------------------------------------------
// pgms_ctrl: sequencer for loading and the end-of-group passes
// issues datapath commands and waits on unit status
// ----------------------------------------------------------------------------
module pgms_ctrl
   import pgms_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_fire,
   input  logic       req_last,
   input  status_type status,
   output cmd_type    cmd,
   output logic       req_ready
);

   state_type    state_ff;
   state_type    state_in;
   res_kind_type kind_ff;
   res_kind_type kind_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kind_ff  <= RES_NODATA;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      unique case (state_ff)
         ST_IDLE: if (req_fire && req_last) state_in = ST_CHECK;
         ST_CHECK: begin
            if (status.count_zero || status.stat_bad) begin
               state_in = ST_EMIT;
               kind_in  = RES_NODATA;
            end else begin
               state_in = ST_P1_RD;
            end
         end
         ST_P1_RD: state_in = ST_P1_ACC;
         ST_P1_ACC: begin
            if (!status.idx_last) begin
               state_in = ST_P1_RD;
            end else if (status.stat_sel == STAT_MAX) begin
               state_in = ST_EMIT;
               kind_in  = RES_MAX;
            end else if (status.stat_sel == STAT_MIN) begin
               state_in = ST_EMIT;
               kind_in  = RES_MIN;
            end else begin
               state_in = ST_MEAN_GO;
            end
         end
         ST_MEAN_GO: state_in = ST_MEAN_WAIT;
         ST_MEAN_WAIT: begin
            if (status.div_done) begin
               if (status.stat_sel == STAT_MEAN) begin
                  state_in = ST_EMIT;
                  kind_in  = RES_MEAN;
               end else begin
                  state_in = ST_P2_RD;
               end
            end
         end
         ST_P2_RD: state_in = ST_P2_GO;
         ST_P2_GO: state_in = ST_P2_WAIT;
         ST_P2_WAIT: begin
            if (status.mul_done) state_in = status.idx_last ? ST_VAR_GO : ST_P2_RD;
         end
         ST_VAR_GO:   state_in = ST_VAR_WAIT;
         ST_VAR_WAIT: if (status.div_done) state_in = ST_SQRT_GO;
         ST_SQRT_GO:  state_in = ST_SQRT_WAIT;
         ST_SQRT_WAIT: if (status.sqrt_done) state_in = ST_SIG_CHK;
         ST_SIG_CHK: begin
            if (status.stat_sel == STAT_STD) begin
               state_in = ST_EMIT;
               kind_in  = RES_STD;
            end else if (status.sigma_zero) begin
               state_in = ST_EMIT;
               kind_in  = RES_DEGEN;
            end else begin
               state_in = ST_P3_RD;
            end
         end
         ST_P3_RD:     state_in = ST_P3_DGO;
         ST_P3_DGO:    state_in = ST_P3_DWAIT;
         ST_P3_DWAIT:  if (status.div_done) state_in = ST_P3_M1GO;
         ST_P3_M1GO:   state_in = ST_P3_M1WAIT;
         ST_P3_M1WAIT: if (status.mul_done) state_in = ST_P3_M2GO;
         ST_P3_M2GO:   state_in = ST_P3_M2WAIT;
         ST_P3_M2WAIT: begin
            if (status.mul_done) state_in = status.idx_last ? ST_FIN_GO : ST_P3_RD;
         end
         ST_FIN_GO: state_in = ST_FIN_WAIT;
         ST_FIN_WAIT: begin
            if (status.div_done) begin
               state_in = ST_EMIT;
               kind_in  = RES_MOMENT;
            end
         end
         ST_EMIT: if (status.out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd         = '0;
      cmd.div_sel = DIV_MEAN;
      cmd.mul_sel = MUL_SQ;
      cmd.kind    = kind_ff;
      unique case (state_ff)
         ST_CHECK:  cmd.idx_clr = 1'b1;
         ST_P1_RD:  cmd.rd = 1'b1;
         ST_P1_ACC: begin
            cmd.p1_acc  = 1'b1;
            cmd.idx_inc = !status.idx_last;
         end
         ST_MEAN_GO: begin
            cmd.div_go  = 1'b1;
            cmd.div_sel = DIV_MEAN;
            cmd.acc_clr = 1'b1;
            cmd.idx_clr = 1'b1;
         end
         ST_P2_RD: cmd.rd = 1'b1;
         ST_P2_GO: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = MUL_SQ;
         end
         ST_P2_WAIT: cmd.idx_inc = status.mul_done && !status.idx_last;
         ST_VAR_GO: begin
            cmd.div_go  = 1'b1;
            cmd.div_sel = DIV_VAR;
         end
         ST_SQRT_GO: cmd.sqrt_go = 1'b1;
         ST_SIG_CHK: begin
            cmd.idx_clr = 1'b1;
            cmd.acc_clr = 1'b1;
         end
         ST_P3_RD: cmd.rd = 1'b1;
         ST_P3_DGO: begin
            cmd.div_go  = 1'b1;
            cmd.div_sel = DIV_Z;
         end
         ST_P3_M1GO: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = MUL_Z2;
         end
         ST_P3_M2GO: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = MUL_ZK;
         end
         ST_P3_M2WAIT: cmd.idx_inc = status.mul_done && !status.idx_last;
         ST_FIN_GO: begin
            cmd.div_go  = 1'b1;
            cmd.div_sel = DIV_FIN;
         end
         ST_EMIT: cmd.emit = status.out_free;
         default: cmd.rd = 1'b0;
      endcase
   end

   assign req_ready = state_ff == ST_IDLE;

endmodule

// File: rtl/peak_group_moment_statistics_unit.sv
// ----------------------------------------------------------------------------
// peak_group_moment_statistics_unit: per-waveform peak statistics
// max, min, mean, std deviation, skewness or kurtosis of one peak property
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid/req_ready   | one peak or end marker
//   rsp     | out       | rsp_valid/rsp_ready   | one statistic per group
//   csr     | in        | csr_wr_en             | csr_index, csr_wdata
//
// a peak that is not the last of its group is taken without leaving idle
// at group end the sequencer runs up to three passes over the n buffered
// values on one shared divider, a digit-serial multiplier and a 32-step
// root unit: max/min need the first pass only, mean adds one quotient, std
// deviation adds a pass with one multiply per value, one quotient and the
// root, and skewness and kurtosis add a pass with a quotient and two
// multiplies per value plus one quotient more
// req_ready is low from the group end until the result is in the output
// register; a stalled result only holds the block once the next group ends
// reset is synchronous and restores the documented register defaults
// ----------------------------------------------------------------------------
module peak_group_moment_statistics_unit
   import pgms_pkg::*;
#(
   parameter int MAX_VALUES = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic               clock,
   input  logic               reset,
   // peak transfer
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_has_peak,
   input  logic signed [31:0] req_amplitude,
   input  logic signed [31:0] req_elevation,
   input  logic signed [31:0] req_pulse_width,
   input  logic signed [31:0] req_rise_span,
   input  logic signed [31:0] req_backscatter,
   input  logic [7:0]         req_position_in_wave,
   input  logic               req_final_peak,
   input  logic               req_last_of_group,
   // result transfer
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_stat_value,
   output logic               rsp_no_data,
   output logic               rsp_degenerate,
   output logic               rsp_overflowed,
   // register writes
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   cmd_type    cmd;
   status_type status;
   logic       req_fire;

   // a transfer happens only while the sequencer is idle
   assign req_fire = req_valid && req_ready;

   pgms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_last  (req_last_of_group),
      .status    (status),
      .cmd       (cmd),
      .req_ready (req_ready)
   );

   // buffer, accumulators, arithmetic units and result register
   pgms_datapath #(
      .MAX_VALUES (MAX_VALUES),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_fire             (req_fire),
      .req_has_peak         (req_has_peak),
      .req_amplitude        (req_amplitude),
      .req_elevation        (req_elevation),
      .req_pulse_width      (req_pulse_width),
      .req_rise_span        (req_rise_span),
      .req_backscatter      (req_backscatter),
      .req_position_in_wave (req_position_in_wave),
      .req_final_peak       (req_final_peak),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_stat_value       (rsp_stat_value),
      .rsp_no_data          (rsp_no_data),
      .rsp_degenerate       (rsp_degenerate),
      .rsp_overflowed       (rsp_overflowed)
   );

endmodule

// File: dv/tb_peak_group_moment_statistics_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_peak_group_moment_statistics_unit: self-checking bench for the peak
// group statistics unit
// peak groups with random content go in through the req channel under random
// gaps and rsp stalls; a behavioral model of the kept values predicts each
// group's statistic, which is compared field by field with the rsp transfers.
// the settings change between phases while the unit is idle
// ----------------------------------------------------------------------------
module tb_peak_group_moment_statistics_unit;
   import pgms_pkg::*;

   localparam int CAPACITY   = 16;
   localparam int FRAC       = 16;
   localparam int STALL_MAX  = 10;
   localparam int IDLE_LIMIT = 200000;
   localparam int PHASES     = 26;
   localparam int PHASE_SIZE = 32;

   typedef struct {
      logic               has_peak;
      logic signed [31:0] prop [5];
      logic [7:0]         position;
      logic               final_peak;
      logic               last;
   } peak_type;

   typedef struct {
      logic [31:0] value;
      logic        no_data;
      logic        degenerate;
      logic        overflowed;
   } stat_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_has_peak = 1'b0;
   logic signed [31:0] req_amplitude = '0;
   logic signed [31:0] req_elevation = '0;
   logic signed [31:0] req_pulse_width = '0;
   logic signed [31:0] req_rise_span = '0;
   logic signed [31:0] req_backscatter = '0;
   logic [7:0]         req_position_in_wave = '0;
   logic               req_final_peak = 1'b0;
   logic               req_last_of_group = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_stat_value;
   logic               rsp_no_data;
   logic               rsp_degenerate;
   logic               rsp_overflowed;
   logic               csr_wr_en = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [31:0]        csr_wdata = '0;

   peak_type        pending_peaks [$];
   stat_result_type expected_stats [$];
   int              failures = 0;

   // settings as the unit holds them
   logic [2:0]  cfg_stat   = STAT_MAX;
   logic [1:0]  cfg_subset = 2'd0;
   logic [2:0]  cfg_prop   = 3'd0;
   logic [31:0] cfg_nodata = NO_DATA_RESET;

   // values kept for the current group
   logic signed [31:0] kept_values [CAPACITY];
   int                 kept_count = 0;
   logic               kept_dropped = 1'b0;

   peak_group_moment_statistics_unit uut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // behavioral model
   // ---------------------------------------------------------------------
   function automatic logic [31:0] clamp32(longint v);
      if (v > longint'(32'sh7FFF_FFFF)) return POS_LIMIT;
      if (v < -longint'(64'sh8000_0000)) return NEG_LIMIT;
      return v[31:0];
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned root;
      longint unsigned one_bit;
      root = 0;
      one_bit = 64'h1 << 62;
      while (one_bit > x) one_bit >>= 2;
      while (one_bit != 0) begin
         if (x >= root + one_bit) begin
            x -= root + one_bit;
            root = (root >> 1) + one_bit;
         end else begin
            root >>= 1;
         end
         one_bit >>= 2;
      end
      return root;
   endfunction

   function automatic stat_result_type summarize_group();
      stat_result_type r;
      longint          n, sum, mean, d, s3;
      longint unsigned m, sq, var_q, sigma, z, z2, z3, s4, zcap;
      logic [127:0]    sq_sum;
      logic signed [31:0] mx, mn;
      r.value = cfg_nodata;
      r.no_data = 1'b1;
      r.degenerate = 1'b0;
      r.overflowed = kept_dropped;
      n = kept_count;
      if (n == 0 || cfg_stat > STAT_KURT) return r;
      r.no_data = 1'b0;
      mx = kept_values[0];
      mn = kept_values[0];
      sum = 0;
      for (int i = 0; i < n; i++) begin
         if (kept_values[i] > mx) mx = kept_values[i];
         if (kept_values[i] < mn) mn = kept_values[i];
         sum += kept_values[i];
      end
      mean = sum / n;
      case (cfg_stat)
         STAT_MAX: begin
            r.value = mx;
            return r;
         end
         STAT_MIN: begin
            r.value = mn;
            return r;
         end
         STAT_MEAN: begin
            r.value = clamp32(mean);
            return r;
         end
         default: ;
      endcase
      // exact sum of squared deviations, then floor divide
      sq_sum = '0;
      for (int i = 0; i < n; i++) begin
         d = longint'(kept_values[i]) - mean;
         m = d < 0 ? -d : d;
         sq = m * m;
         sq_sum += {64'd0, sq};
      end
      var_q = 64'(sq_sum / 128'(n));
      sigma = int_sqrt(var_q);
      if (cfg_stat == STAT_STD) begin
         r.value = sigma > 64'h7FFF_FFFF ? POS_LIMIT : sigma[31:0];
         return r;
      end
      if (sigma == 0) begin
         r.value = cfg_nodata;
         r.no_data = 1'b1;
         r.degenerate = 1'b1;
         return r;
      end
      zcap = (64'd128 << FRAC) - 1;
      s3 = 0;
      s4 = 0;
      for (int i = 0; i < n; i++) begin
         d = longint'(kept_values[i]) - mean;
         m = d < 0 ? -d : d;
         z = (m << FRAC) / sigma;
         if (z > zcap) z = zcap;
         z2 = (z * z) >> FRAC;
         z3 = (z2 * z) >> FRAC;
         s3 += d < 0 ? -longint'(z3) : longint'(z3);
         s4 += (z2 * z2) >> FRAC;
      end
      if (cfg_stat == STAT_SKEW) r.value = clamp32(s3 / n);
      else r.value = clamp32(longint'(s4 / 64'(n)));
      return r;
   endfunction

   task automatic absorb_peak(input peak_type p);
      logic keep;
      int   sel;
      if (p.has_peak) begin
         keep = 1'b1;
         if (cfg_subset == SUBSET_FIRST) keep = (p.position == 8'd1);
         else if (cfg_subset == SUBSET_FINAL) keep = p.final_peak;
         if (keep) begin
            sel = cfg_prop <= PROP_BACK ? int'(cfg_prop) : 0;
            if (kept_count < CAPACITY) begin
               kept_values[kept_count] = p.prop[sel];
               kept_count++;
            end else begin
               kept_dropped = 1'b1;
            end
         end
      end
      if (p.last) begin
         expected_stats.push_back(summarize_group());
         kept_count = 0;
         kept_dropped = 1'b0;
      end
   endtask

   // ---------------------------------------------------------------------
   // req driver
   // ---------------------------------------------------------------------
   peak_type driven_peak;
   int       req_gap = 0;
   logic     req_busy_mode = 1'b1;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // transfer seen at this edge feeds the model first
         if (req_valid && req_ready) absorb_peak(driven_peak);
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_peaks.size() != 0) begin
               driven_peak = pending_peaks.pop_front();
               req_has_peak         <= driven_peak.has_peak;
               req_amplitude        <= driven_peak.prop[0];
               req_elevation        <= driven_peak.prop[1];
               req_pulse_width      <= driven_peak.prop[2];
               req_rise_span        <= driven_peak.prop[3];
               req_backscatter      <= driven_peak.prop[4];
               req_position_in_wave <= driven_peak.position;
               req_final_peak       <= driven_peak.final_peak;
               req_last_of_group    <= driven_peak.last;
               req_valid            <= 1'b1;
               // stretches without gaps now and then
               if ($urandom_range(0, 19) == 0) req_busy_mode = ~req_busy_mode;
               req_gap = req_busy_mode ? $urandom_range(0, STALL_MAX) : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // rsp monitor and checker
   // ---------------------------------------------------------------------
   int   rsp_stall = 0;
   logic rsp_busy_mode = 1'b1;

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      failures++;
   endtask

   always @(posedge clock) begin
      stat_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_stats.size() == 0) begin
               report_mismatch("result transfer with nothing expected");
            end else begin
               want = expected_stats.pop_front();
               if (rsp_stat_value !== want.value)
                  report_mismatch($sformatf("stat_value %h, want %h",
                                            rsp_stat_value, want.value));
               if (rsp_no_data !== want.no_data)
                  report_mismatch($sformatf("no_data %b, want %b",
                                            rsp_no_data, want.no_data));
               if (rsp_degenerate !== want.degenerate)
                  report_mismatch($sformatf("degenerate %b, want %b",
                                            rsp_degenerate, want.degenerate));
               if (rsp_overflowed !== want.overflowed)
                  report_mismatch($sformatf("overflowed %b, want %b",
                                            rsp_overflowed, want.overflowed));
            end
            if ($urandom_range(0, 9) == 0) rsp_busy_mode = ~rsp_busy_mode;
            rsp_stall = rsp_busy_mode ? $urandom_range(0, STALL_MAX) : 0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
         end
         rsp_ready <= (rsp_stall == 0) && !(rsp_valid && rsp_ready && rsp_stall != 0);
      end
   end

   // ---------------------------------------------------------------------
   // watchdog: cycles without any transfer
   // ---------------------------------------------------------------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_STAT:   cfg_stat = data[2:0];
         CSR_SUBSET: cfg_subset = data[1:0];
         CSR_PROP:   cfg_prop = data[2:0];
         default:    cfg_nodata = data;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic peak_type make_peak(input int style, input logic [31:0] base,
                                          input logic last);
      peak_type p;
      p.has_peak = 1'b1;
      for (int k = 0; k < 5; k++) begin
         case (style)
            0:       p.prop[k] = $urandom;
            1:       p.prop[k] = base + $urandom_range(0, 4000) - 2000;
            default: p.prop[k] = base;
         endcase
      end
      p.position = $urandom_range(0, 1) ? 8'd1 : 8'($urandom);
      p.final_peak = $urandom_range(0, 1);
      p.last = last;
      return p;
   endfunction

   // one well-formed group, sometimes with a stray marker or empty
   task automatic queue_group(output int items);
      int          n, style;
      logic [31:0] base;
      peak_type    p;
      items = 0;
      case ($urandom_range(0, 19))
         0:       n = 0;
         1:       n = $urandom_range(15, 19);
         default: n = $urandom_range(1, 6);
      endcase
      style = $urandom_range(0, 5);
      style = style < 2 ? 0 : (style < 5 ? 1 : 2);
      base = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2000000) - 1000000;
      if (n == 0) begin
         p = make_peak(0, 0, 1'b1);
         p.has_peak = 1'b0;
         pending_peaks.push_back(p);
         items = 1;
         return;
      end
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 15) == 0) begin
            p = make_peak(0, 0, 1'b0);
            p.has_peak = 1'b0;
            pending_peaks.push_back(p);
            items++;
         end
         pending_peaks.push_back(make_peak(style, base, i == n - 1));
         items++;
      end
   endtask

   task automatic wait_idle();
      while (pending_peaks.size() != 0 || req_valid || expected_stats.size() != 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   initial begin
      peak_type       p;
      int             count, got;
      logic [31:0]    nodata_pick;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, extremes, empty group, stray marker, overflow
      p = make_peak(0, 0, 1'b0);
      p.prop = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
      pending_peaks.push_back(p);
      p.prop = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
      p.position = 8'hFF;
      pending_peaks.push_back(p);
      p = make_peak(2, 32'd0, 1'b1);
      p.position = 8'd0;
      pending_peaks.push_back(p);
      p.has_peak = 1'b0;
      pending_peaks.push_back(p);
      p.last = 1'b0;
      pending_peaks.push_back(p);
      pending_peaks.push_back(make_peak(0, 0, 1'b1));
      for (int i = 0; i < 17; i++) pending_peaks.push_back(make_peak(0, 0, i == 16));
      wait_idle();

      for (int ph = 1; ph < PHASES; ph++) begin
         case (ph % 4)
            0:       nodata_pick = POS_LIMIT;
            1:       nodata_pick = NEG_LIMIT;
            2:       nodata_pick = NO_DATA_RESET;
            default: nodata_pick = $urandom;
         endcase
         write_reg(CSR_STAT, 32'(ph % 8));
         write_reg(CSR_SUBSET, 32'((ph / 2) % 4));
         write_reg(CSR_PROP, 32'((ph * 3) % 8));
         write_reg(CSR_NODATA, nodata_pick);
         // unknown statistics are rare: stick mostly to the real ones
         count = 0;
         while (count < (ph % 8 > 5 ? PHASE_SIZE / 4 : PHASE_SIZE)) begin
            queue_group(got);
            count += got;
         end
         wait_idle();
      end

      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/pgms_pkg.sv
rtl/pgms_div.sv
rtl/pgms_mul.sv
rtl/pgms_datapath.sv
rtl/pgms_ctrl.sv
rtl/peak_group_moment_statistics_unit.sv
dv/tb_peak_group_moment_statistics_unit.sv
